@@ hw/rtl/hfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Half-fit allocator package
// Shared sizes, codes, command and status types, and bucket helper functions.
// ----------------------------------------------------------------------------
package hfa_pkg;

    localparam int POOL_CHUNKS  = 1024;
    localparam int BUCKET_COUNT = 11;
    localparam int CH_W         = 10;
    localparam int SIZE_W       = 11;
    localparam int LINK_W       = 11;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int START_W      = 4;
    localparam int MEM_DEPTH    = 2 ** CH_W;

    localparam logic [14:0]       MAX_PAYLOAD = 15'd32763;
    localparam logic [SIZE_W-1:0] POOL_SIZE   = SIZE_W'(POOL_CHUNKS);

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_TOO_BIG  = 2'd1,
        RES_NO_FIT   = 2'd2
    } res_status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_IDLE,
        OP_DECODE,
        OP_A_HDR,
        OP_UNL1,
        OP_UNL2,
        OP_SPLIT_G,
        OP_SPLIT_NX,
        OP_SPLIT_H,
        OP_SET_ALLOC,
        OP_FILE1,
        OP_FILE2,
        OP_F_HDR,
        OP_F_X,
        OP_F_P,
        OP_FSET,
        OP_LRD_X,
        OP_LRD_P,
        OP_NMERGE1,
        OP_NMERGE2,
        OP_NMERGE3,
        OP_PMERGE1,
        OP_PMERGE2,
        OP_PMERGE3,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [5:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_HDR,
        S_A_UL1,
        S_A_UL2,
        S_A_SPG,
        S_A_SPNX,
        S_A_SPH,
        S_A_EXACT,
        S_F_HDR,
        S_F_X,
        S_F_P,
        S_F_SEL,
        S_N_LRD,
        S_N_UL1,
        S_N_UL2,
        S_N_M1,
        S_N_M2,
        S_N_M3,
        S_P_LRD,
        S_P_UL1,
        S_P_UL2,
        S_P_M1,
        S_P_M2,
        S_P_M3,
        S_F_SET,
        S_FILE1,
        S_FILE2,
        S_RES_OK,
        S_RES_ZERO,
        S_RES_BIG,
        S_RES_NOFIT
    } hfa_state_t;

    typedef struct packed {
        dp_op_t      op;
        res_status_t res_status;
        logic        res_addr;
    } hfa_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic too_big;
        logic found;
        logic bad_addr;
        logic fits;
        logic split;
        logic blk_alloc;
        logic nf;
        logic pf;
        logic out_free;
    } hfa_stat_t;

    // Bucket of a block size: floor(log2(size)), limited to the top bucket.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [SIZE_W-1:0] size);
        int lg;
        lg = 0;
        for (int k = 1; k < SIZE_W; k++) begin
            if (size[k]) begin
                lg = k;
            end
        end
        if (lg > BUCKET_COUNT - 1) begin
            lg = BUCKET_COUNT - 1;
        end
        return BKT_W'(lg);
    endfunction

    // Number of significant bits of a chunk count.
    function automatic logic [START_W-1:0] bit_len(input logic [CH_W-1:0] t);
        int lg;
        lg = 0;
        for (int k = 0; k < CH_W; k++) begin
            if (t[k]) begin
                lg = k + 1;
            end
        end
        return START_W'(lg);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hfa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Half-fit allocator controller
// Sequences the header and link memory steps of an allocate or a free.
// ----------------------------------------------------------------------------
module hfa_ctrl
    import hfa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire hfa_stat_t stat,
    output hfa_cmd_t       cmd
);

    hfa_state_t state_reg;
    hfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (stat.clr_done) state_next = S_IDLE;
            S_IDLE:    if (s_valid) state_next = S_DECODE;
            S_DECODE: begin
                if (stat.is_free) begin
                    state_next = stat.bad_addr ? S_RES_ZERO : S_F_HDR;
                end else if (stat.too_big) begin
                    state_next = S_RES_BIG;
                end else if (!stat.found) begin
                    state_next = S_RES_NOFIT;
                end else begin
                    state_next = S_A_HDR;
                end
            end
            S_A_HDR:   state_next = stat.fits ? S_A_UL1 : S_RES_NOFIT;
            S_A_UL1:   state_next = S_A_UL2;
            S_A_UL2:   state_next = stat.split ? S_A_SPG : S_A_EXACT;
            S_A_SPG:   state_next = S_A_SPNX;
            S_A_SPNX:  state_next = S_A_SPH;
            S_A_SPH:   state_next = S_FILE1;
            S_A_EXACT: state_next = S_RES_OK;
            S_F_HDR:   state_next = stat.blk_alloc ? S_F_X : S_RES_ZERO;
            S_F_X:     state_next = S_F_P;
            S_F_P:     state_next = S_F_SEL;
            S_F_SEL: begin
                if (stat.nf) begin
                    state_next = S_N_LRD;
                end else if (stat.pf) begin
                    state_next = S_P_LRD;
                end else begin
                    state_next = S_F_SET;
                end
            end
            S_N_LRD:   state_next = S_N_UL1;
            S_N_UL1:   state_next = S_N_UL2;
            S_N_UL2:   state_next = S_N_M1;
            S_N_M1:    state_next = S_N_M2;
            S_N_M2:    state_next = S_N_M3;
            S_N_M3:    state_next = stat.pf ? S_P_LRD : S_F_SET;
            S_P_LRD:   state_next = S_P_UL1;
            S_P_UL1:   state_next = S_P_UL2;
            S_P_UL2:   state_next = S_P_M1;
            S_P_M1:    state_next = S_P_M2;
            S_P_M2:    state_next = S_P_M3;
            S_P_M3:    state_next = S_F_SET;
            S_F_SET:   state_next = S_FILE1;
            S_FILE1:   state_next = S_FILE2;
            S_FILE2:   state_next = stat.is_free ? S_RES_ZERO : S_RES_OK;
            S_RES_OK, S_RES_ZERO, S_RES_BIG, S_RES_NOFIT: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default:   state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '{op: OP_NONE, res_status: RES_OK, res_addr: 1'b0};
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR:   cmd.op = OP_CLEAR;
            S_IDLE: begin
                cmd.op  = OP_IDLE;
                s_ready = 1'b1;
            end
            S_DECODE:  cmd.op = OP_DECODE;
            S_A_HDR:   cmd.op = OP_A_HDR;
            S_A_UL1, S_N_UL1, S_P_UL1: cmd.op = OP_UNL1;
            S_A_UL2, S_N_UL2, S_P_UL2: cmd.op = OP_UNL2;
            S_A_SPG:   cmd.op = OP_SPLIT_G;
            S_A_SPNX:  cmd.op = OP_SPLIT_NX;
            S_A_SPH:   cmd.op = OP_SPLIT_H;
            S_A_EXACT: cmd.op = OP_SET_ALLOC;
            S_F_HDR:   cmd.op = OP_F_HDR;
            S_F_X:     cmd.op = OP_F_X;
            S_F_P:     cmd.op = OP_F_P;
            S_F_SEL:   cmd.op = OP_NONE;
            S_N_LRD:   cmd.op = OP_LRD_X;
            S_N_M1:    cmd.op = OP_NMERGE1;
            S_N_M2:    cmd.op = OP_NMERGE2;
            S_N_M3:    cmd.op = OP_NMERGE3;
            S_P_LRD:   cmd.op = OP_LRD_P;
            S_P_M1:    cmd.op = OP_PMERGE1;
            S_P_M2:    cmd.op = OP_PMERGE2;
            S_P_M3:    cmd.op = OP_PMERGE3;
            S_F_SET:   cmd.op = OP_FSET;
            S_FILE1:   cmd.op = OP_FILE1;
            S_FILE2:   cmd.op = OP_FILE2;
            S_RES_OK: begin
                cmd.op       = OP_RESULT;
                cmd.res_addr = 1'b1;
            end
            S_RES_ZERO: cmd.op = OP_RESULT;
            S_RES_BIG: begin
                cmd.op         = OP_RESULT;
                cmd.res_status = RES_TOO_BIG;
            end
            S_RES_NOFIT: begin
                cmd.op         = OP_RESULT;
                cmd.res_status = RES_NO_FIT;
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/hfa_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Half-fit allocator datapath
// Header and link memories, bucket heads, working registers, result register.
// ----------------------------------------------------------------------------
module hfa_dp
    import hfa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire hfa_cmd_t    cmd,
    output hfa_stat_t        stat,
    input  wire logic        s_valid,
    input  wire logic        s_req_type,
    input  wire logic [14:0] s_req_bytes,
    input  wire logic [12:0] s_free_word_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [12:0]      m_word_addr
);

    // Header fields and bucket links are kept in separate memories so that
    // a single field can be written without a read-modify-write.
    logic [CH_W-1:0]   hdr_prev_mem  [MEM_DEPTH];
    logic [CH_W-1:0]   hdr_next_mem  [MEM_DEPTH];
    logic [SIZE_W-1:0] hdr_size_mem  [MEM_DEPTH];
    logic              hdr_alloc_mem [MEM_DEPTH];
    logic [LINK_W-1:0] lk_prev_mem   [MEM_DEPTH];
    logic [LINK_W-1:0] lk_next_mem   [MEM_DEPTH];

    logic [CH_W-1:0]   rd_prev_reg, rd_next_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic              rd_alloc_reg;
    logic [LINK_W-1:0] lk_rd_prev_reg, lk_rd_next_reg;

    logic [BUCKET_COUNT-1:0] head_vld_reg;
    logic [CH_W-1:0]         head_chunk_reg [BUCKET_COUNT];

    logic              type_reg;
    logic [14:0]       bytes_reg;
    logic [12:0]       waddr_reg;
    logic [SIZE_W-1:0] need_reg, s_reg, xs_reg, ps_reg, fsize_reg;
    logic [CH_W-1:0]   h_reg, prv_reg, nxt_reg, g_reg, xn_reg, bnext_reg, floc_reg;
    logic              nf_reg, pf_reg;
    logic [CH_W-1:0]   clr_cnt_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [12:0]       out_addr_reg;

    // Memory port controls.
    logic              hr_en;
    logic [CH_W-1:0]   hr_addr;
    logic [CH_W-1:0]   hw_addr;
    logic              hw_prev_en, hw_next_en, hw_size_en, hw_alloc_en;
    logic [CH_W-1:0]   hw_prev, hw_next;
    logic [SIZE_W-1:0] hw_size;
    logic              hw_alloc;
    logic              lr_en;
    logic [CH_W-1:0]   lr_addr;
    logic [CH_W-1:0]   lw_addr;
    logic              lw_prev_en, lw_next_en;
    logic [LINK_W-1:0] lw_prev, lw_next;

    // Bucket head port controls.
    logic [BKT_W-1:0]  hd_rd_idx;
    logic [CH_W-1:0]   hd_rd_chunk;
    logic              hd_rd_vld;
    logic              hd_wr_en;
    logic [BKT_W-1:0]  hd_wr_idx;
    logic              hd_wr_vld;
    logic [CH_W-1:0]   hd_wr_chunk;

    logic [14:0]        total;
    logic [15:0]        total_up;
    logic [START_W-1:0] start;
    logic               found;
    logic [BKT_W-1:0]   found_idx;
    logic [CH_W-1:0]    b_chunk;
    logic               bad_addr;
    logic [BKT_W-1:0]   fbkt;
    logic [CH_W-1:0]    g_calc;
    logic [LINK_W-1:0]  pl, nl;
    logic               out_load;

    assign total    = bytes_reg + 15'd4;
    assign total_up = {1'b0, total} + 16'd31;
    assign start    = bit_len(total[14:5]);
    assign b_chunk  = waddr_reg[12:3];
    assign bad_addr = (waddr_reg[2:0] != 3'b001)
                      || ({1'b0, b_chunk} >= SIZE_W'(POOL_CHUNKS));
    assign fbkt     = bucket_of(fsize_reg);
    assign g_calc   = h_reg + need_reg[CH_W-1:0];
    assign pl       = lk_rd_prev_reg;
    assign nl       = lk_rd_next_reg;
    assign out_load = (cmd.op == OP_RESULT) && (!out_valid_reg || m_ready);

    // First nonempty bucket at or above the search start.
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int k = BUCKET_COUNT - 1; k >= 0; k--) begin
            if (head_vld_reg[k] && (k >= int'(start))) begin
                found     = 1'b1;
                found_idx = BKT_W'(k);
            end
        end
    end

    assign hd_rd_idx   = (cmd.op == OP_DECODE) ? found_idx : fbkt;
    assign hd_rd_chunk = head_chunk_reg[hd_rd_idx];
    assign hd_rd_vld   = head_vld_reg[hd_rd_idx];

    always_comb begin
        stat.clr_done  = (clr_cnt_reg == {CH_W{1'b1}});
        stat.is_free   = type_reg;
        stat.too_big   = (bytes_reg > MAX_PAYLOAD);
        stat.found     = found;
        stat.bad_addr  = bad_addr;
        stat.fits      = (rd_size_reg >= need_reg);
        stat.split     = (s_reg > need_reg);
        stat.blk_alloc = rd_alloc_reg;
        stat.nf        = nf_reg;
        stat.pf        = pf_reg;
        stat.out_free  = !out_valid_reg || m_ready;
    end

    // Port controls for each step.
    always_comb begin
        hr_en       = 1'b0;
        hr_addr     = h_reg;
        hw_addr     = h_reg;
        hw_prev_en  = 1'b0;
        hw_next_en  = 1'b0;
        hw_size_en  = 1'b0;
        hw_alloc_en = 1'b0;
        hw_prev     = '0;
        hw_next     = '0;
        hw_size     = '0;
        hw_alloc    = 1'b0;
        lr_en       = 1'b0;
        lr_addr     = h_reg;
        lw_addr     = floc_reg;
        lw_prev_en  = 1'b0;
        lw_next_en  = 1'b0;
        lw_prev     = '0;
        lw_next     = '0;
        hd_wr_en    = 1'b0;
        hd_wr_idx   = fbkt;
        hd_wr_vld   = 1'b0;
        hd_wr_chunk = floc_reg;
        case (cmd.op)
            OP_CLEAR: begin
                hw_addr     = clr_cnt_reg;
                hw_prev_en  = 1'b1;
                hw_next_en  = 1'b1;
                hw_size_en  = 1'b1;
                hw_alloc_en = 1'b1;
                hw_size     = (clr_cnt_reg == '0) ? POOL_SIZE : '0;
                lw_addr     = clr_cnt_reg;
                lw_prev_en  = 1'b1;
                lw_next_en  = 1'b1;
                lw_prev     = {1'b1, CH_W'(bucket_of(POOL_SIZE))};
                lw_next     = {1'b1, CH_W'(bucket_of(POOL_SIZE))};
            end
            OP_DECODE: begin
                hr_en   = 1'b1;
                hr_addr = type_reg ? b_chunk : hd_rd_chunk;
            end
            OP_A_HDR: begin
                lr_en   = 1'b1;
                lr_addr = h_reg;
            end
            OP_UNL1: begin
                if (pl[LINK_W-1]) begin
                    hd_wr_en    = ({1'b0, pl[CH_W-1:0]} < SIZE_W'(BUCKET_COUNT));
                    hd_wr_idx   = pl[BKT_W-1:0];
                    hd_wr_vld   = !nl[LINK_W-1];
                    hd_wr_chunk = nl[CH_W-1:0];
                end else begin
                    lw_addr    = pl[CH_W-1:0];
                    lw_next_en = 1'b1;
                    lw_next    = nl;
                end
            end
            OP_UNL2: begin
                lw_addr    = nl[CH_W-1:0];
                lw_prev_en = !nl[LINK_W-1];
                lw_prev    = pl;
            end
            OP_SPLIT_G: begin
                hw_addr     = g_calc;
                hw_prev_en  = 1'b1;
                hw_next_en  = 1'b1;
                hw_size_en  = 1'b1;
                hw_alloc_en = 1'b1;
                hw_prev     = h_reg;
                hw_next     = (nxt_reg == h_reg) ? g_calc : nxt_reg;
                hw_size     = s_reg - need_reg;
            end
            OP_SPLIT_NX: begin
                hw_addr    = nxt_reg;
                hw_prev_en = (nxt_reg != h_reg);
                hw_prev    = g_reg;
            end
            OP_SPLIT_H: begin
                hw_prev_en  = 1'b1;
                hw_next_en  = 1'b1;
                hw_size_en  = 1'b1;
                hw_alloc_en = 1'b1;
                hw_prev     = prv_reg;
                hw_next     = g_reg;
                hw_size     = need_reg;
                hw_alloc    = 1'b1;
            end
            OP_SET_ALLOC: begin
                hw_alloc_en = 1'b1;
                hw_alloc    = 1'b1;
            end
            OP_F_HDR: begin
                hr_en   = 1'b1;
                hr_addr = rd_next_reg;
            end
            OP_F_X: begin
                hr_en   = 1'b1;
                hr_addr = prv_reg;
            end
            OP_F_P: begin
                hw_alloc_en = 1'b1;
            end
            OP_LRD_X: begin
                lr_en   = 1'b1;
                lr_addr = nxt_reg;
            end
            OP_LRD_P: begin
                lr_en   = 1'b1;
                lr_addr = prv_reg;
            end
            OP_NMERGE1: begin
                hw_addr     = nxt_reg;
                hw_prev_en  = 1'b1;
                hw_next_en  = 1'b1;
                hw_size_en  = 1'b1;
                hw_alloc_en = 1'b1;
            end
            OP_NMERGE2: begin
                hw_next_en = 1'b1;
                hw_size_en = 1'b1;
                hw_next    = bnext_reg;
                hw_size    = s_reg;
            end
            OP_NMERGE3: begin
                hw_addr    = bnext_reg;
                hw_prev_en = (bnext_reg != h_reg);
                hw_prev    = h_reg;
            end
            OP_PMERGE1: begin
                hw_prev_en  = 1'b1;
                hw_next_en  = 1'b1;
                hw_size_en  = 1'b1;
                hw_alloc_en = 1'b1;
            end
            OP_PMERGE2: begin
                hw_addr    = prv_reg;
                hw_next_en = 1'b1;
                hw_size_en = 1'b1;
                hw_next    = bnext_reg;
                hw_size    = s_reg;
            end
            OP_PMERGE3: begin
                hw_addr    = bnext_reg;
                hw_prev_en = (bnext_reg != prv_reg);
                hw_prev    = prv_reg;
            end
            OP_FILE1: begin
                lw_addr    = hd_rd_chunk;
                lw_prev_en = hd_rd_vld;
                lw_prev    = {1'b0, floc_reg};
            end
            OP_FILE2: begin
                lw_prev_en  = 1'b1;
                lw_next_en  = 1'b1;
                lw_prev     = {1'b1, CH_W'(fbkt)};
                lw_next     = hd_rd_vld ? {1'b0, hd_rd_chunk} : {1'b1, CH_W'(fbkt)};
                hd_wr_en    = 1'b1;
                hd_wr_vld   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Header memories.
    always_ff @(posedge aclk) begin
        if (hw_prev_en) hdr_prev_mem[hw_addr] <= hw_prev;
        if (hw_next_en) hdr_next_mem[hw_addr] <= hw_next;
        if (hw_size_en) hdr_size_mem[hw_addr] <= hw_size;
        if (hw_alloc_en) hdr_alloc_mem[hw_addr] <= hw_alloc;
        if (hr_en) begin
            rd_prev_reg  <= hdr_prev_mem[hr_addr];
            rd_next_reg  <= hdr_next_mem[hr_addr];
            rd_size_reg  <= hdr_size_mem[hr_addr];
            rd_alloc_reg <= hdr_alloc_mem[hr_addr];
        end
    end

    // Bucket link memories.
    always_ff @(posedge aclk) begin
        if (lw_prev_en) lk_prev_mem[lw_addr] <= lw_prev;
        if (lw_next_en) lk_next_mem[lw_addr] <= lw_next;
        if (lr_en) begin
            lk_rd_prev_reg <= lk_prev_mem[lr_addr];
            lk_rd_next_reg <= lk_next_mem[lr_addr];
        end
    end

    // Bucket heads: after reset only the bucket of the whole pool holds chunk 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BUCKET_COUNT; k++) begin
                head_vld_reg[k]   <= (BKT_W'(k) == bucket_of(POOL_SIZE));
                head_chunk_reg[k] <= '0;
            end
        end else if (hd_wr_en) begin
            head_vld_reg[hd_wr_idx]   <= hd_wr_vld;
            head_chunk_reg[hd_wr_idx] <= hd_wr_chunk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.op == OP_CLEAR && !stat.clr_done) begin
            clr_cnt_reg <= clr_cnt_reg + CH_W'(1);
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_IDLE: begin
                if (s_valid) begin
                    type_reg  <= s_req_type;
                    bytes_reg <= s_req_bytes;
                    waddr_reg <= s_free_word_addr;
                end
            end
            OP_DECODE: begin
                need_reg <= SIZE_W'(total_up >> 5);
                h_reg    <= type_reg ? b_chunk : hd_rd_chunk;
            end
            OP_A_HDR, OP_F_HDR: begin
                s_reg     <= rd_size_reg;
                prv_reg   <= rd_prev_reg;
                nxt_reg   <= rd_next_reg;
                bnext_reg <= rd_next_reg;
            end
            OP_SPLIT_G: g_reg <= g_calc;
            OP_SPLIT_H: begin
                floc_reg  <= g_reg;
                fsize_reg <= s_reg - need_reg;
            end
            OP_F_X: begin
                nf_reg <= (nxt_reg != h_reg) && !rd_alloc_reg;
                xs_reg <= rd_size_reg;
                xn_reg <= rd_next_reg;
            end
            OP_F_P: begin
                pf_reg <= (prv_reg != h_reg) && !rd_alloc_reg;
                ps_reg <= rd_size_reg;
            end
            OP_NMERGE1: begin
                s_reg     <= s_reg + xs_reg;
                bnext_reg <= (xn_reg == nxt_reg) ? h_reg : xn_reg;
            end
            OP_PMERGE1: begin
                s_reg     <= s_reg + ps_reg;
                bnext_reg <= (bnext_reg == h_reg) ? prv_reg : bnext_reg;
            end
            OP_PMERGE3: h_reg <= prv_reg;
            OP_FSET: begin
                floc_reg  <= h_reg;
                fsize_reg <= s_reg;
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= cmd.res_status;
            out_addr_reg   <= cmd.res_addr ? {h_reg, 3'b001} : 13'd0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_word_addr = out_addr_reg;

endmodule
`default_nettype wire

@@ hw/rtl/half_fit_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Half-fit allocator
// Allocates and frees blocks of 32-byte chunks from a 32 KiB pool.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s_ channel (s_req_type 0 allocates
// s_req_bytes, 1 frees s_free_word_addr) and gives exactly one result on the
// m_ channel: a status and, for a good allocate, the payload word address.
// Requests are handled one at a time. An allocate runs a chain of header and
// link memory accesses: it is refused at decode or at the header check, else
// it unlinks the block and either marks an exact fit allocated or splits it
// and files the remainder. A free checks the address and the block, merges it
// with a free next and then a free previous neighbour, and files it. The next
// request is taken when the state machine is back in idle, entered as its
// result is loaded, even while that result still waits in the output register.
// After reset the block sweeps all 1024 entries of its header and link
// memories, one entry a cycle; s_ready stays low until the sweep is done.
// If the receiver stalls, the result stays in the output register and the
// next request is held before its result is loaded.
// ----------------------------------------------------------------------------
module half_fit_allocator
    import hfa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [14:0] s_req_bytes,
    input  wire logic [12:0] s_free_word_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [12:0]      m_word_addr
);

    hfa_cmd_t  cmd;
    hfa_stat_t stat;

    hfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hfa_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_valid          (s_valid),
        .s_req_type       (s_req_type),
        .s_req_bytes      (s_req_bytes),
        .s_free_word_addr (s_free_word_addr),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_word_addr      (m_word_addr)
    );

endmodule
`default_nettype wire

@@ hw/rtl/hfa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Half-fit allocator port checker
// Checks result channel behaviour as seen on the top-level ports.
// ----------------------------------------------------------------------------
module hfa_checker
    import hfa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [12:0] m_word_addr
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_word_addr))
        else $error("result changed while stalled");

    // A failed request never carries an address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != RES_OK) |-> m_word_addr == 13'd0)
        else $error("failed request returned an address");

    // Every returned address points just past a chunk header.
    a_addr_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word_addr != 13'd0) |-> m_word_addr[2:0] == 3'b001)
        else $error("address not aligned to a chunk payload");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");

    // No request is taken in the cycle after reset is released.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !(s_valid && s_ready))
        else $error("activity straight after reset");

endmodule

bind half_fit_allocator hfa_checker u_hfa_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_word_addr (m_word_addr)
);
`default_nettype wire
